// ===== hw/rtl/ethx_pkg.sv =====
// Package for the Ethernet/IPv4/TCP header extractor.
// Holds byte positions, protocol codes and the result record type.
// No dependencies.
package ethx_pkg;

    localparam int POS_W     = 17;
    localparam int PAYLOAD_W = 17;

    localparam logic [POS_W-1:0] ETH_HDR_BYTES     = 17'd14;
    localparam logic [POS_W-1:0] POS_DMAC_END      = 17'd6;
    localparam logic [POS_W-1:0] POS_SMAC_END      = 17'd12;
    localparam logic [POS_W-1:0] POS_IHL           = 17'd14;
    localparam logic [POS_W-1:0] POS_TLEN_HI       = 17'd16;
    localparam logic [POS_W-1:0] POS_TLEN_LO       = 17'd17;
    localparam logic [POS_W-1:0] POS_TTL           = 17'd22;
    localparam logic [POS_W-1:0] POS_PROTO         = 17'd23;
    localparam logic [POS_W-1:0] POS_SIP           = 17'd26;
    localparam logic [POS_W-1:0] POS_DIP           = 17'd30;
    localparam logic [POS_W-1:0] POS_IP_END        = 17'd34;
    localparam logic [POS_W-1:0] TCP_CAPTURE_BYTES = 17'd14;

    localparam logic [3:0] TCP_K_SEQ   = 4'd4;
    localparam logic [3:0] TCP_K_ACK   = 4'd8;
    localparam logic [3:0] TCP_K_DOFF  = 4'd12;
    localparam logic [3:0] TCP_K_FLAGS = 4'd13;

    localparam logic [3:0] IHL_MIN       = 4'd5;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

    typedef struct packed {
        logic [47:0]                  dst_mac;
        logic [47:0]                  src_mac;
        logic [31:0]                  src_ip;
        logic [31:0]                  dst_ip;
        logic [15:0]                  ip_total_len;
        logic [7:0]                   ttl;
        logic [7:0]                   protocol;
        logic [31:0]                  tcp_ports;
        logic [31:0]                  tcp_seq;
        logic [31:0]                  tcp_ack;
        logic [5:0]                   tcp_flag_bits;
        logic signed [PAYLOAD_W-1:0]  payload_len;
    } t_result;

endpackage

// ===== hw/rtl/ethx_if.sv =====
// Valid/ready channel interfaces of the header extractor: frame bytes in,
// header records out. Depends on ethx_pkg.
interface ethx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ethx_rec_if;
    logic                                    valid;
    logic                                    ready;
    logic [47:0]                             dst_mac;
    logic [47:0]                             src_mac;
    logic [31:0]                             src_ip;
    logic [31:0]                             dst_ip;
    logic [15:0]                             ip_total_len;
    logic [7:0]                              ttl;
    logic [7:0]                              protocol;
    logic [31:0]                             tcp_ports;
    logic [31:0]                             tcp_seq;
    logic [31:0]                             tcp_ack;
    logic [5:0]                              tcp_flag_bits;
    logic signed [ethx_pkg::PAYLOAD_W-1:0]   payload_len;

    modport source (output valid, output dst_mac, output src_mac, output src_ip,
                    output dst_ip, output ip_total_len, output ttl, output protocol,
                    output tcp_ports, output tcp_seq, output tcp_ack, output tcp_flag_bits,
                    output payload_len, input ready);
    modport sink   (input valid, input dst_mac, input src_mac, input src_ip,
                    input dst_ip, input ip_total_len, input ttl, input protocol,
                    input tcp_ports, input tcp_seq, input tcp_ack, input tcp_flag_bits,
                    input payload_len, output ready);
endinterface

// ===== hw/rtl/eth_ipv4_tcp_header_extractor.sv =====
// Top level of the Ethernet/IPv4/TCP header extractor.
// Depends on ethx_pkg and the channel interfaces in ethx_if.
//
// Usage:
//   i_in carries one frame byte per request, in wire order, with last_byte
//   set on the final byte. o_out carries one header record per frame,
//   produced by the request that holds the last byte.
//   Each byte goes through an input register, then field capture that
//   updates the offset counter and field registers. A record is written
//   to the output buffer when its last byte leaves the input register.
//   Throughput is one byte per cycle, set by the single capture stage,
//   but held while a last byte waits. Records sit in a two-entry output
//   buffer. While the receiver stalls, bytes keep flowing; a last byte waits
//   in the input register only when both entries are full, then i_in.ready drops.
//   Reset (i_rst_n low, synchronous) empties the input register and the
//   output buffer and clears the offset counter and all field registers.
//   After each record all capture state clears for the next frame.
//   Frames longer than MAX_FRAME_BYTES are counted as MAX_FRAME_BYTES and
//   bytes beyond that point are ignored.
module eth_ipv4_tcp_header_extractor #(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ethx_byte_if.sink     i_in,
    ethx_rec_if.source    o_out
);

    localparam int OFFSET_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [OFFSET_W-1:0] MAX_OFFSET = OFFSET_W'(MAX_FRAME_BYTES);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    logic [OFFSET_W-1:0] r_offset,   n_offset,   cap_offset;
    logic [3:0]          r_ihl,      n_ihl,      cap_ihl;
    logic [3:0]          r_doff,     n_doff,     cap_doff;
    logic [47:0]         r_dmac,     n_dmac,     cap_dmac;
    logic [47:0]         r_smac,     n_smac,     cap_smac;
    logic [31:0]         r_sip,      n_sip,      cap_sip;
    logic [31:0]         r_dip,      n_dip,      cap_dip;
    logic [15:0]         r_tlen,     n_tlen,     cap_tlen;
    logic [7:0]          r_ttl,      n_ttl,      cap_ttl;
    logic [7:0]          r_proto,    n_proto,    cap_proto;
    logic [31:0]         r_ports,    n_ports,    cap_ports;
    logic [31:0]         r_seq,      n_seq,      cap_seq;
    logic [31:0]         r_ack,      n_ack,      cap_ack;
    logic [5:0]          r_flags,    n_flags,    cap_flags;

    logic [ethx_pkg::POS_W-1:0]     pos;
    logic [ethx_pkg::POS_W-1:0]     tcp_base;
    logic [3:0]                     tcp_k;
    logic [3:0]                     ihl_used;
    logic [3:0]                     cap_ihl_used;
    logic [7:0]                     hdr_bytes;
    logic                           is_tcp;
    ethx_pkg::t_result              result;

    ethx_pkg::t_result r_slot [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_cnt;

    logic advance;
    logic push;
    logic pop;

    // hold a last byte in the input register while the output buffer is full
    assign advance    = !r_in_last || (r_cnt != 2'd2);
    assign i_in.ready = !r_in_valid || advance;
    assign push       = r_in_valid && advance && r_in_last;
    assign pop        = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    assign ihl_used = (r_ihl < ethx_pkg::IHL_MIN) ? ethx_pkg::IHL_MIN : r_ihl;
    assign pos      = ethx_pkg::POS_W'(r_offset);
    assign tcp_base = ethx_pkg::ETH_HDR_BYTES + {11'd0, ihl_used, 2'b00};
    assign tcp_k    = 4'(pos - tcp_base);

    always_comb begin
        cap_offset = r_offset;
        cap_ihl    = r_ihl;
        cap_doff   = r_doff;
        cap_dmac   = r_dmac;
        cap_smac   = r_smac;
        cap_sip    = r_sip;
        cap_dip    = r_dip;
        cap_tlen   = r_tlen;
        cap_ttl    = r_ttl;
        cap_proto  = r_proto;
        cap_ports  = r_ports;
        cap_seq    = r_seq;
        cap_ack    = r_ack;
        cap_flags  = r_flags;
        if (r_offset < MAX_OFFSET) begin
            cap_offset = r_offset + OFFSET_W'(1);
            priority if (pos < ethx_pkg::POS_DMAC_END) begin
                cap_dmac = {r_dmac[39:0], r_in_byte};
            end else if (pos < ethx_pkg::POS_SMAC_END) begin
                cap_smac = {r_smac[39:0], r_in_byte};
            end else if (pos == ethx_pkg::POS_IHL) begin
                cap_ihl = r_in_byte[3:0];
            end else if (pos == ethx_pkg::POS_TLEN_HI || pos == ethx_pkg::POS_TLEN_LO) begin
                cap_tlen = {r_tlen[7:0], r_in_byte};
            end else if (pos == ethx_pkg::POS_TTL) begin
                cap_ttl = r_in_byte;
            end else if (pos == ethx_pkg::POS_PROTO) begin
                cap_proto = r_in_byte;
            end else if (pos >= ethx_pkg::POS_SIP && pos < ethx_pkg::POS_DIP) begin
                cap_sip = {r_sip[23:0], r_in_byte};
            end else if (pos >= ethx_pkg::POS_DIP && pos < ethx_pkg::POS_IP_END) begin
                cap_dip = {r_dip[23:0], r_in_byte};
            end
            if (pos >= tcp_base && pos < tcp_base + ethx_pkg::TCP_CAPTURE_BYTES) begin
                priority if (tcp_k < ethx_pkg::TCP_K_SEQ) begin
                    cap_ports = {r_ports[23:0], r_in_byte};
                end else if (tcp_k < ethx_pkg::TCP_K_ACK) begin
                    cap_seq = {r_seq[23:0], r_in_byte};
                end else if (tcp_k < ethx_pkg::TCP_K_DOFF) begin
                    cap_ack = {r_ack[23:0], r_in_byte};
                end else if (tcp_k == ethx_pkg::TCP_K_DOFF) begin
                    cap_doff = r_in_byte[7:4];
                end else begin
                    cap_flags = r_in_byte[5:0];
                end
            end
        end
    end

    assign cap_ihl_used = (cap_ihl < ethx_pkg::IHL_MIN) ? ethx_pkg::IHL_MIN : cap_ihl;
    assign is_tcp       = (cap_proto == ethx_pkg::PROTO_TCP);

    always_comb begin
        hdr_bytes = 8'(ethx_pkg::ETH_HDR_BYTES) + {2'b00, cap_ihl_used, 2'b00};
        if (is_tcp) begin
            hdr_bytes = hdr_bytes + {2'b00, cap_doff, 2'b00};
        end else if (cap_proto == ethx_pkg::PROTO_UDP) begin
            hdr_bytes = hdr_bytes + ethx_pkg::UDP_HDR_BYTES;
        end
    end

    always_comb begin
        result.dst_mac       = cap_dmac;
        result.src_mac       = cap_smac;
        result.src_ip        = cap_sip;
        result.dst_ip        = cap_dip;
        result.ip_total_len  = cap_tlen;
        result.ttl           = cap_ttl;
        result.protocol      = cap_proto;
        result.tcp_ports     = is_tcp ? cap_ports : 32'd0;
        result.tcp_seq       = is_tcp ? cap_seq   : 32'd0;
        result.tcp_ack       = is_tcp ? cap_ack   : 32'd0;
        result.tcp_flag_bits = is_tcp ? cap_flags : 6'd0;
        result.payload_len   = $signed(ethx_pkg::PAYLOAD_W'(cap_offset)
                                       - ethx_pkg::PAYLOAD_W'(hdr_bytes));
    end

    always_comb begin
        n_offset = r_offset;
        n_ihl    = r_ihl;
        n_doff   = r_doff;
        n_dmac   = r_dmac;
        n_smac   = r_smac;
        n_sip    = r_sip;
        n_dip    = r_dip;
        n_tlen   = r_tlen;
        n_ttl    = r_ttl;
        n_proto  = r_proto;
        n_ports  = r_ports;
        n_seq    = r_seq;
        n_ack    = r_ack;
        n_flags  = r_flags;
        if (r_in_valid && advance) begin
            if (r_in_last) begin
                n_offset = '0;
                n_ihl    = '0;
                n_doff   = '0;
                n_dmac   = '0;
                n_smac   = '0;
                n_sip    = '0;
                n_dip    = '0;
                n_tlen   = '0;
                n_ttl    = '0;
                n_proto  = '0;
                n_ports  = '0;
                n_seq    = '0;
                n_ack    = '0;
                n_flags  = '0;
            end else begin
                n_offset = cap_offset;
                n_ihl    = cap_ihl;
                n_doff   = cap_doff;
                n_dmac   = cap_dmac;
                n_smac   = cap_smac;
                n_sip    = cap_sip;
                n_dip    = cap_dip;
                n_tlen   = cap_tlen;
                n_ttl    = cap_ttl;
                n_proto  = cap_proto;
                n_ports  = cap_ports;
                n_seq    = cap_seq;
                n_ack    = cap_ack;
                n_flags  = cap_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_ihl    <= '0;
            r_doff   <= '0;
            r_dmac   <= '0;
            r_smac   <= '0;
            r_sip    <= '0;
            r_dip    <= '0;
            r_tlen   <= '0;
            r_ttl    <= '0;
            r_proto  <= '0;
            r_ports  <= '0;
            r_seq    <= '0;
            r_ack    <= '0;
            r_flags  <= '0;
        end else begin
            r_offset <= n_offset;
            r_ihl    <= n_ihl;
            r_doff   <= n_doff;
            r_dmac   <= n_dmac;
            r_smac   <= n_smac;
            r_sip    <= n_sip;
            r_dip    <= n_dip;
            r_tlen   <= n_tlen;
            r_ttl    <= n_ttl;
            r_proto  <= n_proto;
            r_ports  <= n_ports;
            r_seq    <= n_seq;
            r_ack    <= n_ack;
            r_flags  <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (push) begin
            r_slot[r_wptr] <= result;
        end
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.dst_mac       = r_slot[r_rptr].dst_mac;
    assign o_out.src_mac       = r_slot[r_rptr].src_mac;
    assign o_out.src_ip        = r_slot[r_rptr].src_ip;
    assign o_out.dst_ip        = r_slot[r_rptr].dst_ip;
    assign o_out.ip_total_len  = r_slot[r_rptr].ip_total_len;
    assign o_out.ttl           = r_slot[r_rptr].ttl;
    assign o_out.protocol      = r_slot[r_rptr].protocol;
    assign o_out.tcp_ports     = r_slot[r_rptr].tcp_ports;
    assign o_out.tcp_seq       = r_slot[r_rptr].tcp_seq;
    assign o_out.tcp_ack       = r_slot[r_rptr].tcp_ack;
    assign o_out.tcp_flag_bits = r_slot[r_rptr].tcp_flag_bits;
    assign o_out.payload_len   = r_slot[r_rptr].payload_len;

endmodule

// ===== tb/eth_ipv4_tcp_header_extractor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for eth_ipv4_tcp_header_extractor: drives frames byte by byte and
// checks every header record against an in-bench field predictor or a fixed expected record.
// Depends on ethx_pkg, ethx_byte_if / ethx_rec_if and the extractor RTL.
module eth_ipv4_tcp_header_extractor_tb;

    localparam int FRAME_CAP  = 65536;
    localparam int TIMEOUT_NS = 10_000_000;

    typedef struct packed {
        logic [16:0] pos;
        logic [3:0]  ihl;
        logic [3:0]  doff;
        logic [47:0] dmac;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] tlen;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] ports;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
    } t_hdr_acc;

    typedef struct {
        int unsigned       n_bytes;
        logic [7:0]        fill;
        bit                shaped;
        logic [7:0]        ver_ihl;
        logic [7:0]        proto_b;
        logic [7:0]        doff_b;
        logic [7:0]        flag_b;
        bit                typed;
        ethx_pkg::t_result want;
    } t_frame_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ethx_byte_if in_if ();
    ethx_rec_if  out_if ();

    eth_ipv4_tcp_header_extractor #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_hdr_acc          hdr_acc;
    ethx_pkg::t_result pending_recs[$];
    t_frame_row        plan[$];
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       bytes_sent;
    int unsigned       frames_sent;
    int unsigned       records_seen = 0;
    int unsigned       mismatches = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned tcp_start(input logic [3:0] ihl);
        return ethx_pkg::ETH_HDR_BYTES
               + 4 * int'((ihl < ethx_pkg::IHL_MIN) ? ethx_pkg::IHL_MIN : ihl);
    endfunction

    function automatic bit absorb_byte(input logic [7:0] b, input bit l,
                                       output ethx_pkg::t_result rec);
        int unsigned p;
        int unsigned t;
        int unsigned k;
        int unsigned hdr;
        logic [31:0] diff;
        rec = '0;
        t = tcp_start(hdr_acc.ihl);
        if (hdr_acc.pos < FRAME_CAP) begin
            p = hdr_acc.pos;
            if (p < ethx_pkg::POS_DMAC_END) begin
                hdr_acc.dmac = {hdr_acc.dmac[39:0], b};
            end else if (p < ethx_pkg::POS_SMAC_END) begin
                hdr_acc.smac = {hdr_acc.smac[39:0], b};
            end else if (p == ethx_pkg::POS_IHL) begin
                hdr_acc.ihl = b[3:0];
            end else if (p == ethx_pkg::POS_TLEN_HI || p == ethx_pkg::POS_TLEN_LO) begin
                hdr_acc.tlen = {hdr_acc.tlen[7:0], b};
            end else if (p == ethx_pkg::POS_TTL) begin
                hdr_acc.ttl = b;
            end else if (p == ethx_pkg::POS_PROTO) begin
                hdr_acc.proto = b;
            end else if (p >= ethx_pkg::POS_SIP && p < ethx_pkg::POS_DIP) begin
                hdr_acc.sip = {hdr_acc.sip[23:0], b};
            end else if (p >= ethx_pkg::POS_DIP && p < ethx_pkg::POS_IP_END) begin
                hdr_acc.dip = {hdr_acc.dip[23:0], b};
            end
            if (p >= t && p < t + ethx_pkg::TCP_CAPTURE_BYTES) begin
                k = p - t;
                if (k < ethx_pkg::TCP_K_SEQ) begin
                    hdr_acc.ports = {hdr_acc.ports[23:0], b};
                end else if (k < ethx_pkg::TCP_K_ACK) begin
                    hdr_acc.seq = {hdr_acc.seq[23:0], b};
                end else if (k < ethx_pkg::TCP_K_DOFF) begin
                    hdr_acc.ack = {hdr_acc.ack[23:0], b};
                end else if (k == ethx_pkg::TCP_K_DOFF) begin
                    hdr_acc.doff = b[7:4];
                end else begin
                    hdr_acc.flags = b[5:0];
                end
            end
            hdr_acc.pos = hdr_acc.pos + 1'b1;
        end
        if (!l) return 1'b0;

        hdr = tcp_start(hdr_acc.ihl);
        if (hdr_acc.proto == ethx_pkg::PROTO_TCP) begin
            hdr += 4 * int'(hdr_acc.doff);
            rec.tcp_ports     = hdr_acc.ports;
            rec.tcp_seq       = hdr_acc.seq;
            rec.tcp_ack       = hdr_acc.ack;
            rec.tcp_flag_bits = hdr_acc.flags;
        end else if (hdr_acc.proto == ethx_pkg::PROTO_UDP) begin
            hdr += ethx_pkg::UDP_HDR_BYTES;
        end
        diff = hdr_acc.pos - hdr;
        rec.dst_mac      = hdr_acc.dmac;
        rec.src_mac      = hdr_acc.smac;
        rec.src_ip       = hdr_acc.sip;
        rec.dst_ip       = hdr_acc.dip;
        rec.ip_total_len = hdr_acc.tlen;
        rec.ttl          = hdr_acc.ttl;
        rec.protocol     = hdr_acc.proto;
        rec.payload_len  = diff[ethx_pkg::PAYLOAD_W-1:0];
        hdr_acc = '0;
        return 1'b1;
    endfunction

    function automatic void flag_error(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s expected %0h, got %0h", $time, what, want, got);
    endfunction

    task automatic check_record();
        ethx_pkg::t_result want;
        records_seen++;
        if (pending_recs.size() == 0) begin
            flag_error("record with none pending, dst_mac", '0, out_if.dst_mac);
            return;
        end
        want = pending_recs.pop_front();
        if (out_if.dst_mac !== want.dst_mac)
            flag_error("dst_mac", want.dst_mac, out_if.dst_mac);
        if (out_if.src_mac !== want.src_mac)
            flag_error("src_mac", want.src_mac, out_if.src_mac);
        if (out_if.src_ip !== want.src_ip)
            flag_error("src_ip", want.src_ip, out_if.src_ip);
        if (out_if.dst_ip !== want.dst_ip)
            flag_error("dst_ip", want.dst_ip, out_if.dst_ip);
        if (out_if.ip_total_len !== want.ip_total_len)
            flag_error("ip_total_len", want.ip_total_len, out_if.ip_total_len);
        if (out_if.ttl !== want.ttl)
            flag_error("ttl", want.ttl, out_if.ttl);
        if (out_if.protocol !== want.protocol)
            flag_error("protocol", want.protocol, out_if.protocol);
        if (out_if.tcp_ports !== want.tcp_ports)
            flag_error("tcp_ports", want.tcp_ports, out_if.tcp_ports);
        if (out_if.tcp_seq !== want.tcp_seq)
            flag_error("tcp_seq", want.tcp_seq, out_if.tcp_seq);
        if (out_if.tcp_ack !== want.tcp_ack)
            flag_error("tcp_ack", want.tcp_ack, out_if.tcp_ack);
        if (out_if.tcp_flag_bits !== want.tcp_flag_bits)
            flag_error("tcp_flag_bits", want.tcp_flag_bits, out_if.tcp_flag_bits);
        if (out_if.payload_len !== want.payload_len)
            flag_error("payload_len", want.payload_len, out_if.payload_len);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_record();
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void place_headers(ref logic [7:0] fr[$], input logic [7:0] ver_ihl,
                                          input logic [7:0] proto_b, input logic [7:0] doff_b,
                                          input logic [7:0] flag_b);
        int unsigned base;
        base = tcp_start(ver_ihl[3:0]);
        if (fr.size() > ethx_pkg::POS_IHL) fr[ethx_pkg::POS_IHL] = ver_ihl;
        if (fr.size() > ethx_pkg::POS_PROTO) fr[ethx_pkg::POS_PROTO] = proto_b;
        if (fr.size() > base + ethx_pkg::TCP_K_DOFF) fr[base + ethx_pkg::TCP_K_DOFF] = doff_b;
        if (fr.size() > base + ethx_pkg::TCP_K_FLAGS) fr[base + ethx_pkg::TCP_K_FLAGS] = flag_b;
    endfunction

    task automatic send_frame(ref logic [7:0] fr[$], input bit typed,
                              input ethx_pkg::t_result want);
        ethx_pkg::t_result rec;
        for (int i = 0; i < fr.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_if.valid <= 1'b0;
                @(posedge clk);
            end
            in_if.valid     <= 1'b1;
            in_if.data_byte <= fr[i];
            in_if.last_byte <= (i == fr.size() - 1);
            do @(posedge clk); while (in_if.ready !== 1'b1);
            bytes_sent++;
            if (absorb_byte(fr[i], i == fr.size() - 1, rec))
                pending_recs.push_back(typed ? want : rec);
        end
        frames_sent++;
    endtask

    task automatic send_random_frame();
        logic [7:0]  fr[$];
        int unsigned ihl_v;
        int unsigned doff_v;
        int unsigned len;
        int unsigned pick;
        logic [7:0]  proto_b;
        fr = {};
        if ($urandom_range(99) < 20) begin
            len = $urandom_range(90, 1);
            repeat (len) fr.push_back(8'($urandom_range(255)));
        end else begin
            ihl_v  = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
            doff_v = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
            pick   = $urandom_range(9);
            proto_b = (pick < 4) ? ethx_pkg::PROTO_TCP :
                      (pick < 7) ? ethx_pkg::PROTO_UDP : 8'($urandom_range(255));
            len = tcp_start(ihl_v[3:0]) + $urandom_range(30);
            if (proto_b == ethx_pkg::PROTO_TCP)
                len += 4 * doff_v;
            else if (proto_b == ethx_pkg::PROTO_UDP)
                len += ethx_pkg::UDP_HDR_BYTES;
            if ($urandom_range(7) == 0) len = $urandom_range(len, 1);
            repeat (len) fr.push_back(8'($urandom_range(255)));
            place_headers(fr, {4'($urandom_range(15)), ihl_v[3:0]}, proto_b,
                          {doff_v[3:0], 4'($urandom_range(15))}, 8'($urandom_range(255)));
        end
        send_frame(fr, 1'b0, '0);
    endtask

    task automatic run_random(input int unsigned byte_goal, input int unsigned frame_goal);
        int unsigned b0;
        int unsigned f0;
        b0 = bytes_sent;
        f0 = frames_sent;
        while (bytes_sent - b0 < byte_goal || frames_sent - f0 < frame_goal)
            send_random_frame();
    endtask

    task automatic add_row(input int unsigned n, input logic [7:0] fill, input bit shaped,
                           input logic [7:0] ver_ihl, input logic [7:0] proto_b,
                           input logic [7:0] doff_b, input logic [7:0] flag_b,
                           input bit typed, input ethx_pkg::t_result want);
        t_frame_row row;
        row.n_bytes = n;
        row.fill    = fill;
        row.shaped  = shaped;
        row.ver_ihl = ver_ihl;
        row.proto_b = proto_b;
        row.doff_b  = doff_b;
        row.flag_b  = flag_b;
        row.typed   = typed;
        row.want    = want;
        plan.push_back(row);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d records still pending", pending_recs.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [7:0] fr[$];
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        hdr_acc         = '0;
        send_idle_pct   = 25;
        recv_idle_pct   = 53;
        bytes_sent      = 0;
        frames_sent     = 0;

        add_row(1, 8'h00, 0, '0, '0, '0, '0, 1, '{payload_len: -17'sd33, default: '0});
        add_row(1, 8'hFF, 0, '0, '0, '0, '0, 1,
                '{dst_mac: 48'hFF, payload_len: -17'sd33, default: '0});
        add_row(14, 8'hFF, 0, '0, '0, '0, '0, 1,
                '{dst_mac: '1, src_mac: '1, payload_len: -17'sd20, default: '0});
        add_row(60, 8'hFF, 0, '0, '0, '0, '0, 1,
                '{dst_mac: '1, src_mac: '1, src_ip: '1, dst_ip: '1, ip_total_len: '1,
                  ttl: '1, protocol: '1, payload_len: -17'sd14, default: '0});
        add_row(42, 8'h00, 1, 8'h45, ethx_pkg::PROTO_UDP, '0, '0, 1,
                '{protocol: ethx_pkg::PROTO_UDP, default: '0});
        add_row(54, 8'hA5, 1, 8'h40, ethx_pkg::PROTO_TCP, 8'h50, 8'h3F, 0, '0);
        add_row(144, 8'h5A, 1, 8'h4F, ethx_pkg::PROTO_TCP, 8'hF0, 8'hFF, 0, '0);
        add_row(134, 8'h96, 1, 8'h4F, ethx_pkg::PROTO_TCP, 8'hFF, 8'h00, 0, '0);
        add_row(40, 8'hC3, 1, 8'h46, ethx_pkg::PROTO_TCP, 8'h50, 8'h12, 0, '0);
        add_row(30, 8'h81, 1, 8'h43, ethx_pkg::PROTO_UDP, '0, '0, 0, '0);
        add_row(60, 8'h7E, 1, 8'h45, ethx_pkg::PROTO_TCP, 8'h00, 8'h2A, 0, '0);
        add_row(200, 8'h3C, 1, 8'h45, ethx_pkg::PROTO_TCP, 8'h50, 8'h12, 0, '0);
        add_row(1, 8'h80, 0, '0, '0, '0, '0, 1,
                '{dst_mac: 48'h80, payload_len: -17'sd33, default: '0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r]) begin
            fr = {};
            repeat (plan[r].n_bytes) fr.push_back(plan[r].fill);
            if (plan[r].shaped)
                place_headers(fr, plan[r].ver_ihl, plan[r].proto_b, plan[r].doff_b,
                              plan[r].flag_b);
            send_frame(fr, plan[r].typed, plan[r].want);
        end

        run_random(250, 3);
        send_idle_pct = 53;
        recv_idle_pct = 25;
        run_random(250, 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(250, 3);

        in_if.valid <= 1'b0;
        while (pending_recs.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d frames (%0d bytes) and checked %0d header records, %0d mismatches.",
                 frames_sent, bytes_sent, records_seen, mismatches);
        $display("Frames spanned one-byte, truncated, small-IHL, TCP/UDP/other and long ones.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
